// ===== rtl/dlie_pkg.sv =====
package dlie_pkg;

    // Default pool geometry.
    localparam int DLIE_CAPACITY   = 16;
    localparam int DLIE_DATA_WIDTH = 32;

    // Fixed field widths of the transaction formats.
    localparam int OP_W       = 3;
    localparam int CONTENT_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 32;
    localparam int COUNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST  = 3'd0,
        OP_LAST   = 3'd1,
        OP_NEXT   = 3'd2,
        OP_READ   = 3'd3,
        OP_APPEND = 3'd4,
        OP_INSERT = 3'd5,
        OP_DELETE = 3'd6
    } dlie_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NO_ITER = 2'd3
    } dlie_status_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [CONTENT_W-1:0] content;
    } dlie_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_DATA_W-1:0] data;
        logic                  iterator_valid;
        logic [COUNT_W-1:0]    count;
    } dlie_out_t;

endpackage

// ===== rtl/dlie_free_slot.sv =====
module dlie_free_slot #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 5
) (
    input  logic [CAPACITY-1:0] used_map,
    output logic [IDX_W-1:0]    slot,
    output logic                slot_ok
);

    // Priority encoder: the lowest clear bit of the used map wins. With no
    // clear bit the slot reads as the none marker.
    always_comb begin
        slot = IDX_W'(CAPACITY);
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!used_map[i]) begin
                slot = IDX_W'(i);
            end
        end
        slot_ok = ~&used_map;
    end

endmodule

// ===== rtl/dlie_payload_mem.sv =====
module dlie_payload_mem #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int SLOT_W     = 4
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [SLOT_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [SLOT_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the word is held until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/doubly_linked_list_iterator_engine_core.sv =====
// Doubly linked list engine with an iterator, over a fixed pool of CAPACITY
// node slots.
// Input channel (s_valid, s_ready, s_payload): each transaction carries one
// command (first, last, next, read, append, insert after iterator, delete)
// and a payload word used by append and insert.
// Result channel (m_valid, m_ready, m_payload): exactly one result per
// command with status, read data, iterator validity and node count.
// The command is executed at the edge it is accepted and its result is valid
// in the following cycle. Throughput is one transaction per cycle while the
// receiver takes results; the whole command is a single pass through the
// link registers, the lowest-free-slot encoder and the payload memory port.
// A new command is accepted while the result register is empty or is being
// emptied in the same cycle. When the receiver stalls, the result is held
// and s_ready drops until it is taken, so nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the list: head, tail and
// iterator become none, all slots free, count zero, no result pending.
// Payload and link storage is not cleared; only linked slots are ever read.
module doubly_linked_list_iterator_engine_core #(
    parameter int CAPACITY   = dlie_pkg::DLIE_CAPACITY,
    parameter int DATA_WIDTH = dlie_pkg::DLIE_DATA_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dlie_pkg::dlie_in_t s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output dlie_pkg::dlie_out_t m_payload
);

    import dlie_pkg::*;

    // Index width must hold the none marker, which is the value CAPACITY.
    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] NONE = IDX_W'(CAPACITY);

    // List state.
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    iter_reg, iter_next;
    logic [CAPACITY-1:0] used_reg, used_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    next_link_reg [CAPACITY];
    logic [IDX_W-1:0]    next_link_next [CAPACITY];
    logic [IDX_W-1:0]    prev_link_reg [CAPACITY];
    logic [IDX_W-1:0]    prev_link_next [CAPACITY];

    // Result register.
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                iter_valid_reg;
    logic [COUNT_W-1:0]  count_out_reg;
    logic                data_sel_reg;

    logic                  accept;
    logic [IDX_W-1:0]      slot;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     slot_s;
    logic [SLOT_W-1:0]     iter_s;
    logic                  it_ok;
    logic                  head_ok;
    logic [IDX_W-1:0]      it_after;
    logic [IDX_W-1:0]      it_before;
    logic [STATUS_W-1:0]   status_next;
    logic                  rd_hit;
    logic                  mem_wr;
    logic [DATA_WIDTH-1:0] rd_data;

    // The result register frees up in the same cycle it is read out.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    dlie_free_slot #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_free_slot (
        .used_map (used_reg),
        .slot     (slot),
        .slot_ok  (slot_ok)
    );

    assign slot_s  = slot[SLOT_W-1:0];
    assign iter_s  = iter_reg[SLOT_W-1:0];
    assign it_ok   = iter_reg < NONE;
    assign head_ok = head_reg < NONE;

    // Neighbors of the node under the iterator; none when there is no iterator.
    assign it_after  = it_ok ? next_link_reg[iter_s] : NONE;
    assign it_before = it_ok ? prev_link_reg[iter_s] : NONE;

    // Command decode and the whole list update, one pass per command.
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        iter_next      = iter_reg;
        used_next      = used_reg;
        count_next     = count_reg;
        next_link_next = next_link_reg;
        prev_link_next = prev_link_reg;
        status_next    = ST_OK;
        rd_hit         = 1'b0;
        mem_wr         = 1'b0;

        case (s_payload.operation)
            OP_FIRST: begin
                if (!head_ok) begin
                    status_next = ST_EMPTY;
                end else begin
                    iter_next = head_reg;
                end
            end
            OP_LAST: begin
                if (!(tail_reg < NONE)) begin
                    status_next = ST_EMPTY;
                end else begin
                    iter_next = tail_reg;
                end
            end
            OP_NEXT: begin
                if (!it_ok || !(it_after < NONE)) begin
                    status_next = ST_EMPTY;
                end else begin
                    iter_next = it_after;
                end
            end
            OP_READ: begin
                if (!it_ok) begin
                    status_next = ST_NO_ITER;
                end else begin
                    rd_hit = 1'b1;
                end
            end
            OP_APPEND, OP_INSERT: begin
                if (!slot_ok) begin
                    status_next = ST_FULL;
                end else if (!head_ok) begin
                    // First node of an empty list is head, tail and iterator.
                    prev_link_next[slot_s] = NONE;
                    next_link_next[slot_s] = NONE;
                    head_next = slot;
                    tail_next = slot;
                    iter_next = slot;
                    mem_wr    = 1'b1;
                end else if (s_payload.operation == OP_APPEND) begin
                    prev_link_next[slot_s] = tail_reg;
                    next_link_next[slot_s] = NONE;
                    next_link_next[tail_reg[SLOT_W-1:0]] = slot;
                    tail_next = slot;
                    mem_wr    = 1'b1;
                end else if (!it_ok) begin
                    status_next = ST_NO_ITER;
                end else begin
                    prev_link_next[slot_s] = iter_reg;
                    next_link_next[slot_s] = it_after;
                    next_link_next[iter_s] = slot;
                    if (it_after < NONE) begin
                        prev_link_next[it_after[SLOT_W-1:0]] = slot;
                    end else begin
                        tail_next = slot;
                    end
                    mem_wr = 1'b1;
                end
                if (mem_wr) begin
                    used_next[slot_s] = 1'b1;
                    count_next = count_reg + IDX_W'(1);
                end
            end
            OP_DELETE: begin
                if (!head_ok) begin
                    status_next = ST_EMPTY;
                end else if (!it_ok) begin
                    status_next = ST_NO_ITER;
                end else begin
                    // Head and tail are compared with the old iterator index.
                    if (it_before < NONE) begin
                        next_link_next[it_before[SLOT_W-1:0]] = it_after;
                    end
                    if (it_after < NONE) begin
                        prev_link_next[it_after[SLOT_W-1:0]] = it_before;
                    end
                    if (tail_reg == iter_reg) begin
                        tail_next = it_before;
                    end
                    if (head_reg == iter_reg) begin
                        head_next = it_after;
                    end
                    used_next[iter_s] = 1'b0;
                    if (count_reg != '0) begin
                        count_next = count_reg - IDX_W'(1);
                    end
                    iter_next = (it_after < NONE) ? it_after : it_before;
                end
            end
            default: begin
            end
        endcase
    end

    dlie_payload_mem #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .SLOT_W     (SLOT_W)
    ) u_payload_mem (
        .aclk    (aclk),
        .wr_en   (accept && mem_wr),
        .wr_addr (slot_s),
        .wr_data (DATA_WIDTH'(s_payload.content)),
        .rd_en   (accept && rd_hit),
        .rd_addr (iter_s),
        .rd_data (rd_data)
    );

    // Control state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= NONE;
            tail_reg    <= NONE;
            iter_reg    <= NONE;
            used_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                iter_reg  <= iter_next;
                used_reg  <= used_next;
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Link storage and result payload; only meaningful where linked or valid.
    always_ff @(posedge aclk) begin
        if (accept) begin
            next_link_reg  <= next_link_next;
            prev_link_reg  <= prev_link_next;
            status_reg     <= status_next;
            iter_valid_reg <= iter_next < NONE;
            count_out_reg  <= COUNT_W'(count_next);
            data_sel_reg   <= rd_hit;
        end
    end

    assign m_valid                  = m_valid_reg;
    assign m_payload.status         = status_reg;
    assign m_payload.data           = data_sel_reg ? OUT_DATA_W'(rd_data) : '0;
    assign m_payload.iterator_valid = iter_valid_reg;
    assign m_payload.count          = count_out_reg;

`ifndef SYNTH
    // The used map and the node count always agree.
    a_count_matches_map: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == int'(count_reg))
        else $error("node count differs from used slot map");

    // Head and tail are either both nodes or both none.
    a_head_tail_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg < NONE) == (tail_reg < NONE))
        else $error("head and tail disagree on list emptiness");

    // An empty list has no iterator.
    a_empty_no_iter: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == NONE && iter_reg == NONE))
        else $error("empty list with a live head or iterator");

    // Every accepted command yields a pending result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted command produced no result");
`endif

endmodule

// ===== tb/sv/dlie_list_checker.sv =====
module dlie_list_checker #(
    parameter int CAPACITY = dlie_pkg::DLIE_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  dlie_pkg::dlie_in_t  s_payload,
    input  logic                m_valid,
    input  logic                m_ready,
    input  dlie_pkg::dlie_out_t m_payload,
    output int                  mismatch_count,
    output int                  results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dlie_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);
    localparam int PRINT_CAP = 100;

    // Private copy of the node pool, kept in step with every accepted command.
    logic [CONTENT_W-1:0] node_word [CAPACITY];
    logic [IDX_W-1:0]     fwd_link  [CAPACITY];
    logic [IDX_W-1:0]     back_link [CAPACITY];
    logic [IDX_W-1:0]     head_idx;
    logic [IDX_W-1:0]     tail_idx;
    logic [IDX_W-1:0]     cursor;
    logic [CAPACITY-1:0]  occupied;
    logic [COUNT_W-1:0]   nodes;

    dlie_out_t awaited_results[$];

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    // Slot position of a node index that is known to be a real node.
    function automatic logic [SLOT_W-1:0] pos(logic [IDX_W-1:0] idx);
        return idx[SLOT_W-1:0];
    endfunction

    function automatic void clear_list();
        head_idx = NIL;
        tail_idx = NIL;
        cursor   = NIL;
        occupied = '0;
        nodes    = '0;
    endfunction

    // Applies one command to the private pool and returns the result it must produce.
    function automatic dlie_out_t execute_command(dlie_in_t cmd);
        dlie_out_t        res;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] succ;
        logic [IDX_W-1:0] pred;
        res = '0;
        res.status = ST_OK;
        case (cmd.operation)
            OP_FIRST: begin
                if (head_idx == NIL) res.status = ST_EMPTY;
                else cursor = head_idx;
            end
            OP_LAST: begin
                if (tail_idx == NIL) res.status = ST_EMPTY;
                else cursor = tail_idx;
            end
            OP_NEXT: begin
                if (cursor == NIL || fwd_link[pos(cursor)] == NIL) res.status = ST_EMPTY;
                else cursor = fwd_link[pos(cursor)];
            end
            OP_READ: begin
                if (cursor == NIL) res.status = ST_NO_ITER;
                else res.data = node_word[pos(cursor)];
            end
            OP_APPEND, OP_INSERT: begin
                slot = NIL;
                for (int i = CAPACITY - 1; i >= 0; i--) begin
                    if (!occupied[i]) slot = IDX_W'(i);
                end
                if (slot == NIL) begin
                    res.status = ST_FULL;
                end else if (head_idx == NIL) begin
                    node_word[pos(slot)] = cmd.content;
                    back_link[pos(slot)] = NIL;
                    fwd_link[pos(slot)]  = NIL;
                    head_idx = slot;
                    tail_idx = slot;
                    cursor   = slot;
                end else if (cmd.operation == OP_APPEND) begin
                    node_word[pos(slot)] = cmd.content;
                    back_link[pos(slot)] = tail_idx;
                    fwd_link[pos(slot)]  = NIL;
                    fwd_link[pos(tail_idx)] = slot;
                    tail_idx = slot;
                end else if (cursor == NIL) begin
                    res.status = ST_NO_ITER;
                end else begin
                    succ = fwd_link[pos(cursor)];
                    node_word[pos(slot)] = cmd.content;
                    back_link[pos(slot)] = cursor;
                    fwd_link[pos(slot)]  = succ;
                    fwd_link[pos(cursor)] = slot;
                    if (succ != NIL) back_link[pos(succ)] = slot;
                    else tail_idx = slot;
                end
                if (res.status == ST_OK) begin
                    occupied[pos(slot)] = 1'b1;
                    nodes = nodes + 1'b1;
                end
            end
            OP_DELETE: begin
                if (head_idx == NIL) begin
                    res.status = ST_EMPTY;
                end else if (cursor == NIL) begin
                    res.status = ST_NO_ITER;
                end else begin
                    pred = back_link[pos(cursor)];
                    succ = fwd_link[pos(cursor)];
                    if (pred != NIL) fwd_link[pos(pred)] = succ;
                    if (succ != NIL) back_link[pos(succ)] = pred;
                    if (tail_idx == cursor) tail_idx = pred;
                    if (head_idx == cursor) head_idx = succ;
                    occupied[pos(cursor)] = 1'b0;
                    if (nodes != 0) nodes = nodes - 1'b1;
                    cursor = (succ != NIL) ? succ : pred;
                end
            end
            default: ;
        endcase
        res.iterator_valid = (cursor != NIL);
        res.count = nodes;
        return res;
    endfunction

    // Printing stops after a while so a badly broken design cannot flood the log.
    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        dlie_out_t want;
        if (!aresetn) begin
            clear_list();
            awaited_results.delete();
        end else begin
            // A result at this edge belongs to an earlier command, so retire it first.
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", m_payload.data, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_payload.status !== want.status)
                        flag_mismatch("status", 32'(m_payload.status), 32'(want.status));
                    if (m_payload.data !== want.data)
                        flag_mismatch("data", m_payload.data, want.data);
                    if (m_payload.iterator_valid !== want.iterator_valid)
                        flag_mismatch("iterator_valid", 32'(m_payload.iterator_valid),
                                      32'(want.iterator_valid));
                    if (m_payload.count !== want.count)
                        flag_mismatch("count", 32'(m_payload.count), 32'(want.count));
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(execute_command(s_payload));
        end
        results_pending <= awaited_results.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dlie_pkg::*;

    // The design has no code for operation value 7; it must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Items per idling phase, and how often the random mix swaps between
    // growing and shrinking the list.
    localparam int PHASE_ITEMS   = 500;
    localparam int TREND_SPAN    = 48;
    // Length of the long receiver hold-off and number of transactions that
    // are pushed at the design while it lasts.
    localparam int HOLDOFF_CYCLES = 200;
    localparam int BURST_ITEMS    = 24;
    // The longest correct stretch without any handshake is the hold-off, so
    // the watchdog limit is set well above it.
    localparam int STALL_LIMIT    = 2000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    dlie_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dlie_out_t m_payload;

    int list_errors;
    int results_pending;

    // Idling controls. The sender percentage is only used by the stimulus
    // process; the receiver percentage and the hold-off request counter are
    // updated with nonblocking assignments so the receiver process sees them
    // without racing the stimulus.
    int tx_idle_pct      = 0;
    int rx_stall_pct     = 0;
    int holdoff_requests = 0;
    int holdoff_seen     = 0;
    int holdoff_left     = 0;
    int quiet_cycles     = 0;
    int item_total       = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    doubly_linked_list_iterator_engine_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    dlie_list_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .mismatch_count  (list_errors),
        .results_pending (results_pending)
    );

    // The receiver either stalls at random or, when a hold-off has been
    // requested, keeps ready low for a fixed number of cycles counted here.
    always @(posedge aclk) begin
        if (holdoff_seen != holdoff_requests) begin
            holdoff_seen <= holdoff_requests;
            holdoff_left <= HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // The watchdog ends the run if neither channel completes a transaction
    // for too long, which also catches a result that never arrives.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic dlie_in_t make_cmd(logic [OP_W-1:0] op, logic [CONTENT_W-1:0] word);
        dlie_in_t cmd;
        cmd.operation = op;
        cmd.content   = word;
        return cmd;
    endfunction

    // Random commands come in two moods. While the list is being grown,
    // appends and inserts dominate so the pool regularly fills up and reports
    // full; while it is being shrunk, deletes dominate so it regularly runs
    // empty and the empty-list cases get exercised. Navigation and reads are
    // mixed in throughout so the iterator wanders over the whole list.
    function automatic dlie_in_t random_command(bit filling);
        logic [OP_W-1:0]      op;
        logic [CONTENT_W-1:0] word;
        int                   roll;
        roll = $urandom_range(99);
        if (filling) begin
            if (roll < 30)      op = OP_APPEND;
            else if (roll < 50) op = OP_INSERT;
            else if (roll < 58) op = OP_DELETE;
            else if (roll < 64) op = OP_FIRST;
            else if (roll < 70) op = OP_LAST;
            else if (roll < 83) op = OP_NEXT;
            else if (roll < 97) op = OP_READ;
            else                op = OP_UNUSED;
        end else begin
            if (roll < 8)       op = OP_APPEND;
            else if (roll < 14) op = OP_INSERT;
            else if (roll < 52) op = OP_DELETE;
            else if (roll < 60) op = OP_FIRST;
            else if (roll < 68) op = OP_LAST;
            else if (roll < 80) op = OP_NEXT;
            else if (roll < 97) op = OP_READ;
            else                op = OP_UNUSED;
        end
        // Payload extremes show up often enough to be read back several times.
        roll = $urandom_range(7);
        if (roll == 0)      word = '0;
        else if (roll == 1) word = '1;
        else                word = $urandom;
        return make_cmd(op, word);
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    // Valid is only ever assigned once per edge: either lowered for an idle
    // cycle or raised together with the new payload.
    task automatic send_command(dlie_in_t cmd);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops offering and waits until every outstanding result has been seen.
    // The pending count is a registered copy, hence the first wait.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    task automatic run_random(int items);
        for (int n = 0; n < items; n++) begin
            send_command(random_command(((item_total / TREND_SPAN) % 2) == 0));
            item_total++;
        end
    endtask

    int idle_plan[4]  = '{0, 55, 0, 16};
    int stall_plan[4] = '{0, 0, 55, 16};

    initial begin
        // Reset is held low at the start and then released for good.
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with no idling on either side. It starts with every command
        // but append on an empty list, then builds a short list and walks it.
        send_command(make_cmd(OP_READ,   32'h0));
        send_command(make_cmd(OP_FIRST,  32'h0));
        send_command(make_cmd(OP_LAST,   32'h0));
        send_command(make_cmd(OP_NEXT,   32'h0));
        send_command(make_cmd(OP_DELETE, 32'h0));
        send_command(make_cmd(OP_UNUSED, 32'hFFFF_FFFF));
        // An insert into an empty list behaves like an append and sets the iterator.
        send_command(make_cmd(OP_INSERT, 32'h0000_0000));
        send_command(make_cmd(OP_APPEND, 32'hFFFF_FFFF));
        send_command(make_cmd(OP_APPEND, 32'hA5A5_A5A5));
        // The iterator is still on the first node, so this lands in the middle.
        send_command(make_cmd(OP_INSERT, 32'h5A5A_5A5A));
        send_command(make_cmd(OP_READ,   32'h0));
        send_command(make_cmd(OP_NEXT,   32'h0));
        send_command(make_cmd(OP_READ,   32'h0));
        send_command(make_cmd(OP_LAST,   32'h0));
        send_command(make_cmd(OP_READ,   32'h0));
        // Next at the tail reports no next node and leaves the iterator alone.
        send_command(make_cmd(OP_NEXT,   32'h0));
        // Deleting the tail moves the iterator back to the previous node.
        send_command(make_cmd(OP_DELETE, 32'h0));
        send_command(make_cmd(OP_READ,   32'h0));
        send_command(make_cmd(OP_FIRST,  32'h0));
        // Deleting the head moves the iterator forward; a fresh append then
        // reuses the lowest freed slot.
        send_command(make_cmd(OP_DELETE, 32'h0));
        send_command(make_cmd(OP_READ,   32'h0));
        send_command(make_cmd(OP_APPEND, 32'h8000_0001));
        send_command(make_cmd(OP_LAST,   32'h0));
        send_command(make_cmd(OP_READ,   32'h0));
        drain_results();

        // Random part, one phase per idling mix.
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct   = idle_plan[p];
            rx_stall_pct <= stall_plan[p];
            run_random(PHASE_ITEMS);
            // The sender pauses here until every expected result is in.
            drain_results();

            if (p == 0) begin
                // Back-pressure: the receiver holds off for a long stretch
                // while the sender keeps offering, so the result register
                // fills and the design has to stall its input.
                holdoff_requests <= holdoff_requests + 1;
                run_random(BURST_ITEMS);
                drain_results();
            end
        end

        // A few more cycles let any stray extra result show up as a mismatch.
        repeat (8) @(posedge aclk);
        if (list_errors == 0 && results_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== doubly_linked_list_iterator_engine_core.f =====
rtl/dlie_pkg.sv
rtl/dlie_free_slot.sv
rtl/dlie_payload_mem.sv
rtl/doubly_linked_list_iterator_engine_core.sv
tb/sv/dlie_list_checker.sv
tb/sv/tb_top.sv
